// ----- rtl/sparse_span_image_fader_macros.svh -----
// assertion macros shared by the sparse span image fader rtl
// depends on nothing; included by modules that carry concurrent checks
`ifndef SPARSE_SPAN_IMAGE_FADER_MACROS_SVH
`define SPARSE_SPAN_IMAGE_FADER_MACROS_SVH

// generic clocked check with explicit clock and reset
`define SSIF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on the block clock, idle during reset
`define SSIF_ASSERT_DEFAULT(label, prop, msg) \
   `SSIF_ASSERT(label, clock, reset, prop, msg)

`endif

// ----- rtl/ssif_pkg.sv -----
// types and constants for the sparse span image fader
// no dependencies; imported by every module of the block
package ssif_pkg;

   // field widths
   localparam int WORD_WIDTH       = 32;
   localparam int BYTE_WIDTH       = 8;
   localparam int LANE_COUNT       = WORD_WIDTH / BYTE_WIDTH;
   localparam int FADE_WIDTH       = 9;
   localparam int ADDR_FIELD_WIDTH = 30;
   localparam int SKIP_WIDTH       = 17;
   localparam int LEN_WIDTH        = 14;
   localparam int END_BIT          = 31;
   localparam int RSP_DATA_WIDTH   = 64;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 30;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEST_BASE   = 8'd0,
      CSR_FADE_AMOUNT = 8'd1
   } csr_index_type;

   // base register update toward the span controller
   typedef struct packed {
      logic                        load;
      logic [ADDR_FIELD_WIDTH-1:0] base;
   } base_cfg_type;

   // what the span controller decides for one transaction
   typedef struct packed {
      logic                        valid;
      logic                        done;
      logic                        span_open;
      logic [ADDR_FIELD_WIDTH-1:0] address;
   } span_result_type;

endpackage

// ----- rtl/sparse_span_image_fader.sv -----
// sparse span image fader: each result is registered in the output register or, on a stall, in the skid entry
// throughput one transaction per cycle, headers included, while req_tready is high; four byte lanes fade in parallel
// a two-entry output stage (register plus skid) absorbs an output stall without loss;
// req_tready then stays low while the skid entry holds a result
// synchronous active-high reset clears pointer, span count, registers and output valids
// configuration writes are taken every cycle (csr_ready is always high)
`include "sparse_span_image_fader_macros.svh"

module sparse_span_image_fader
   import ssif_pkg::*;
#(
   parameter int ADDRESS_WIDTH = 30
) (
   input  logic                       clock,
   input  logic                       reset,
   // configuration write channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   // input stream
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [WORD_WIDTH-1:0]      req_tdata,   // [31:0] stream_word
   // result stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,   // [29:0] write_address, [61:30] pixel_word
   output logic                       rsp_tuser    // [0] image_done
);

   logic                         accept;
   logic                         cfg_write;
   base_cfg_type                 base_cfg;
   span_result_type              result;
   logic [FADE_WIDTH-1:0]        fade_ff, fade_in;
   logic [WORD_WIDTH-1:0]        faded_word;
   logic [WORD_WIDTH-1:0]        pixel_word;
   logic [RSP_DATA_WIDTH-1:0]    new_data;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0]    rsp_data_ff, rsp_data_in;
   logic                         rsp_done_ff, rsp_done_in;
   logic                         skid_valid_ff, skid_valid_in;
   logic [RSP_DATA_WIDTH-1:0]    skid_data_ff, skid_data_in;
   logic                         skid_done_ff, skid_done_in;
   logic                         out_free;
   logic                         produce;

   // handshakes
   assign csr_ready  = 1'b1;
   assign cfg_write  = csr_valid && csr_ready;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign produce    = accept && result.valid;

   // register decode
   always_comb begin
      fade_in       = fade_ff;
      base_cfg.load = 1'b0;
      base_cfg.base = csr_data[ADDR_FIELD_WIDTH-1:0];
      if (cfg_write) begin
         unique case (csr_index)
            CSR_DEST_BASE:   base_cfg.load = 1'b1;
            CSR_FADE_AMOUNT: fade_in = csr_data[FADE_WIDTH-1:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_ff <= '0;
      end else begin
         fade_ff <= fade_in;
      end
   end

   // header decode and pointer tracking
   ssif_span_ctrl #(
      .ADDRESS_WIDTH (ADDRESS_WIDTH)
   ) u_span_ctrl (
      .clock       (clock),
      .reset       (reset),
      .base_cfg    (base_cfg),
      .accept      (accept),
      .stream_word (req_tdata),
      .result      (result)
   );

   // byte lanes
   for (genvar lane = 0; lane < LANE_COUNT; lane++) begin : g_lane
      ssif_fade_lane u_fade_lane (
         .pixel_in  (req_tdata[lane*BYTE_WIDTH +: BYTE_WIDTH]),
         .fade      (fade_ff),
         .pixel_out (faded_word[lane*BYTE_WIDTH +: BYTE_WIDTH])
      );
   end

   // merge lanes with address; end-of-image carries zero payload
   assign pixel_word = result.done ? '0 : faded_word;
   assign new_data   = {{(RSP_DATA_WIDTH-ADDR_FIELD_WIDTH-WORD_WIDTH){1'b0}},
                        pixel_word, result.address};

   // output register with skid entry
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_done_in   = rsp_done_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_done_in  = skid_done_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            rsp_done_in   = skid_done_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = produce;
            rsp_data_in  = new_data;
            rsp_done_in  = result.done;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_data_in  = new_data;
         skid_done_in  = result.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      rsp_done_ff  <= rsp_done_in;
      skid_data_ff <= skid_data_in;
      skid_done_ff <= skid_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_done_ff;

   // checks
   `SSIF_ASSERT_DEFAULT(a_skid_behind_out, skid_valid_ff |-> rsp_valid_ff, "skid without output")
   `SSIF_ASSERT_DEFAULT(a_done_zero, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0, "done payload")
   `SSIF_ASSERT_DEFAULT(a_data_word_result, accept && result.span_open |=> rsp_tvalid, "lost")

endmodule

// ----- rtl/ssif_fade_lane.sv -----
// one pixel byte lane: add the signed fade amount and clamp below at zero
// depends on ssif_pkg
module ssif_fade_lane
   import ssif_pkg::*;
(
   input  logic [BYTE_WIDTH-1:0]  pixel_in,
   input  logic [FADE_WIDTH-1:0]  fade,
   output logic [BYTE_WIDTH-1:0]  pixel_out
);

   logic signed [FADE_WIDTH:0] sum;

   // byte plus sign-extended fade, one bit of headroom
   assign sum = $signed({2'b00, pixel_in}) + $signed({fade[FADE_WIDTH-1], fade});

   // negative sums clamp to zero, overflow above 255 wraps
   assign pixel_out = sum[FADE_WIDTH] ? '0 : sum[BYTE_WIDTH-1:0];

endmodule

// ----- rtl/ssif_span_ctrl.sv -----
// span header decode, write pointer and span length tracking
// depends on ssif_pkg
module ssif_span_ctrl
   import ssif_pkg::*;
#(
   parameter int ADDRESS_WIDTH = 30
) (
   input  logic                  clock,
   input  logic                  reset,
   input  base_cfg_type          base_cfg,
   input  logic                  accept,
   input  logic [WORD_WIDTH-1:0] stream_word,
   output span_result_type       result
);

   logic [ADDR_FIELD_WIDTH-1:0] dest_base_ff, dest_base_in;
   logic [ADDRESS_WIDTH-1:0]    pointer_ff, pointer_in;
   logic [LEN_WIDTH-1:0]        span_ff, span_in;
   logic                        span_open;

   assign span_open = (span_ff != '0);

   // result decision for the current word
   always_comb begin
      result.span_open = span_open;
      result.valid     = span_open || stream_word[END_BIT];
      result.done      = !span_open && stream_word[END_BIT];
      result.address   = span_open ? ADDR_FIELD_WIDTH'(pointer_ff) : '0;
   end

   // next state
   always_comb begin
      dest_base_in = dest_base_ff;
      pointer_in   = pointer_ff;
      span_in      = span_ff;
      if (base_cfg.load) begin
         dest_base_in = base_cfg.base;
         pointer_in   = base_cfg.base[ADDRESS_WIDTH-1:0];
      end else if (accept) begin
         if (span_open) begin
            pointer_in = pointer_ff + ADDRESS_WIDTH'(1);
            span_in    = span_ff - LEN_WIDTH'(1);
         end else if (stream_word[END_BIT]) begin
            pointer_in = dest_base_ff[ADDRESS_WIDTH-1:0];
         end else begin
            pointer_in = pointer_ff
                       + {{(ADDRESS_WIDTH-SKIP_WIDTH){1'b0}}, stream_word[SKIP_WIDTH-1:0]};
            span_in    = stream_word[SKIP_WIDTH +: LEN_WIDTH];
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_base_ff <= '0;
         pointer_ff   <= '0;
         span_ff      <= '0;
      end else begin
         dest_base_ff <= dest_base_in;
         pointer_ff   <= pointer_in;
         span_ff      <= span_in;
      end
   end

endmodule

// ----- dv/ssif_checker.sv -----
// checker for the sparse span image fader: watches the csr, req and rsp channels
// predicts every pixel write and image end and compares them in order
// depends on ssif_pkg for field widths and register indexes
module ssif_checker
   import ssif_pkg::*;
#(
   parameter int ADDRESS_WIDTH = 30
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [WORD_WIDTH-1:0]      req_tdata,   // [31:0] stream_word
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,   // [29:0] write_address, [61:30] pixel_word
   input  logic                       rsp_tuser,   // [0] image_done
   output int                         fail_count,
   output int                         pending,
   output int                         writes_seen,
   output int                         ends_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ADDR_FIELD_WIDTH-1:0] address;
      logic [WORD_WIDTH-1:0]       pixels;
      logic                        done;
   } pixel_write_type;

   pixel_write_type expected_writes[$];

   // shadow of the block state and registers
   logic [ADDRESS_WIDTH-1:0]    write_ptr;
   logic [LEN_WIDTH-1:0]        span_left;
   logic [ADDR_FIELD_WIDTH-1:0] base_reg;
   logic signed [FADE_WIDTH-1:0] fade_reg;

   initial begin
      fail_count  = 0;
      writes_seen = 0;
      ends_seen   = 0;
      pending     = 0;
   end

   // one byte: add, floor at zero, keep low byte
   function automatic logic [BYTE_WIDTH-1:0] fade_lane(input logic [BYTE_WIDTH-1:0] lane,
                                                       input logic signed [FADE_WIDTH-1:0] amount);
      int sum;
      sum = int'(lane) + int'(amount);
      if (sum < 0) begin
         sum = 0;
      end
      return sum[BYTE_WIDTH-1:0];
   endfunction

   function automatic logic [WORD_WIDTH-1:0] fade_word(input logic [WORD_WIDTH-1:0] word,
                                                       input logic signed [FADE_WIDTH-1:0] amount);
      logic [WORD_WIDTH-1:0] faded;
      for (int i = 0; i < LANE_COUNT; i++) begin
         faded[BYTE_WIDTH*i +: BYTE_WIDTH] = fade_lane(word[BYTE_WIDTH*i +: BYTE_WIDTH], amount);
      end
      return faded;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      $display("%0t ns mismatch %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   // header decode or pixel write for one accepted stream word
   task automatic predict_word(input logic [WORD_WIDTH-1:0] word);
      pixel_write_type w;
      w = '0;
      if (span_left == 0) begin
         if (word[END_BIT]) begin
            write_ptr = base_reg[ADDRESS_WIDTH-1:0];
            w.done = 1'b1;
            expected_writes.push_back(w);
         end else begin
            write_ptr = write_ptr + word[SKIP_WIDTH-1:0];
            span_left = word[SKIP_WIDTH +: LEN_WIDTH];
         end
      end else begin
         w.address = ADDR_FIELD_WIDTH'(write_ptr);
         w.pixels  = fade_word(word, fade_reg);
         expected_writes.push_back(w);
         write_ptr = write_ptr + 1'b1;
         span_left = span_left - 1'b1;
      end
   endtask

   // compare one accepted result with the oldest prediction
   task automatic check_result();
      pixel_write_type want;
      if (expected_writes.size() == 0) begin
         report_mismatch("result with nothing expected", rsp_tdata, '0);
      end else begin
         want = expected_writes.pop_front();
         if (rsp_tdata[ADDR_FIELD_WIDTH-1:0] !== want.address) begin
            report_mismatch("write_address", rsp_tdata[ADDR_FIELD_WIDTH-1:0], want.address);
         end
         if (rsp_tdata[ADDR_FIELD_WIDTH +: WORD_WIDTH] !== want.pixels) begin
            report_mismatch("pixel_word", rsp_tdata[ADDR_FIELD_WIDTH +: WORD_WIDTH],
                            want.pixels);
         end
         if (rsp_tuser !== want.done) begin
            report_mismatch("image_done", rsp_tuser, want.done);
         end
         if (want.done) begin
            ends_seen++;
         end else begin
            writes_seen++;
         end
      end
   endtask

   // sample all three channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         write_ptr = '0;
         span_left = '0;
         base_reg  = '0;
         fade_reg  = '0;
         expected_writes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEST_BASE: begin
                  base_reg  = csr_data;
                  write_ptr = csr_data[ADDRESS_WIDTH-1:0];
               end
               CSR_FADE_AMOUNT: begin
                  fade_reg = csr_data[FADE_WIDTH-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_word(req_tdata);
         end
      end
      pending <= expected_writes.size();
   end

endmodule

// ----- dv/sparse_span_image_fader_tb.sv -----
// top of the sparse span image fader testbench: clock, reset, stimulus and verdict
// drives span images with random gaps and stalls; depends on ssif_pkg, ssif_checker and sparse_span_image_fader
module sparse_span_image_fader_tb
   import ssif_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADDRESS_WIDTH  = 30;
   localparam int WATCHDOG_LIMIT = 400;
   localparam int DRAIN_PAUSE    = 4;
   localparam int END_PAUSE      = 8;
   localparam int RANDOM_WORDS   = 750;
   localparam int PHASE_WORDS    = 100;
   localparam int MAX_GAP        = 11;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 8'd2;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [WORD_WIDTH-1:0]      req_tdata;   // [31:0] stream_word
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;   // [29:0] write_address, [61:30] pixel_word
   logic                       rsp_tuser;   // [0] image_done

   int fail_count;
   int pending;
   int writes_seen;
   int ends_seen;
   int words_sent = 0;
   int settings_written = 0;
   int idle_cycles = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   always #1 clock = ~clock;

   sparse_span_image_fader #(
      .ADDRESS_WIDTH(ADDRESS_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ssif_checker #(
      .ADDRESS_WIDTH(ADDRESS_WIDTH)
   ) u_check (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .pending     (pending),
      .writes_seen (writes_seen),
      .ends_seen   (ends_seen)
   );

   // watchdog: cycles without any transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  idle_cycles, pending);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side: random stall before each result
   initial begin
      int gap;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         gap = rsp_calm ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // one stream word; tvalid stays high on return
   task automatic send_word(input logic [WORD_WIDTH-1:0] word);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // drop tvalid, drain every result, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   // csr write; csr_valid stays high on return
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      settings_written++;
   endtask

   function automatic logic [CSR_DATA_WIDTH-1:0] fade_value(input int amount);
      logic [CSR_DATA_WIDTH-1:0] v;
      v = '0;
      v[FADE_WIDTH-1:0] = amount[FADE_WIDTH-1:0];
      return v;
   endfunction

   function automatic logic [WORD_WIDTH-1:0] span_header(input logic [LEN_WIDTH-1:0] len,
                                                         input logic [SKIP_WIDTH-1:0] skip);
      return {1'b0, len, skip};
   endfunction

   // pixel data, half the time built from edge byte values
   function automatic logic [WORD_WIDTH-1:0] pixel_sample();
      logic [WORD_WIDTH-1:0] w;
      w = $urandom;
      if ($urandom_range(0, 1) == 0) begin
         for (int i = 0; i < LANE_COUNT; i++) begin
            case ($urandom_range(0, 6))
               0: w[BYTE_WIDTH*i +: BYTE_WIDTH] = 8'h00;
               1: w[BYTE_WIDTH*i +: BYTE_WIDTH] = 8'h01;
               2: w[BYTE_WIDTH*i +: BYTE_WIDTH] = 8'h7F;
               3: w[BYTE_WIDTH*i +: BYTE_WIDTH] = 8'h80;
               4: w[BYTE_WIDTH*i +: BYTE_WIDTH] = 8'hFE;
               5: w[BYTE_WIDTH*i +: BYTE_WIDTH] = 8'hFF;
               default: begin
               end
            endcase
         end
      end
      return w;
   endfunction

   function automatic logic [LEN_WIDTH-1:0] draw_len();
      case ($urandom_range(0, 9))
         0:       return '0;
         7, 8:    return LEN_WIDTH'($urandom_range(9, 40));
         default: return LEN_WIDTH'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [SKIP_WIDTH-1:0] draw_skip();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return SKIP_WIDTH'($urandom_range(1, 16));
         2:       return {SKIP_WIDTH{1'b1}};
         default: return r[SKIP_WIDTH-1:0];
      endcase
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] draw_base();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return {CSR_DATA_WIDTH{1'b1}};
         2:       return CSR_DATA_WIDTH'({CSR_DATA_WIDTH{1'b1}} - $urandom_range(0, 8));
         default: return r[CSR_DATA_WIDTH-1:0];
      endcase
   endfunction

   function automatic int draw_fade();
      case ($urandom_range(0, 5))
         0:       return 255;
         1:       return -255;
         2:       return 0;
         default: return int'($urandom_range(0, 510)) - 255;
      endcase
   endfunction

   // header followed by its data words
   task automatic send_span(input logic [LEN_WIDTH-1:0] len, input logic [SKIP_WIDTH-1:0] skip);
      send_word(span_header(len, skip));
      repeat (len) send_word(pixel_sample());
   endtask

   task automatic end_image();
      logic [31:0] r;
      r = $urandom;
      send_word({1'b1, r[END_BIT-1:0]});
   endtask

   initial begin
      int phase;
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // brightest fade, base at the top so the pointer wraps inside a span
      settle();
      write_reg(CSR_FADE_AMOUNT, fade_value(255));
      write_reg(CSR_DEST_BASE, {CSR_DATA_WIDTH{1'b1}} - 1'b1);
      csr_valid <= 1'b0;
      send_word(span_header(14'd4, '0));
      send_word(32'h00FF7F80);
      send_word(32'h01020304);
      send_word(32'hFFFFFFFF);
      send_word(32'h00000000);
      // empty span with the largest skip, then a one-word span and image end
      send_word(span_header('0, {SKIP_WIDTH{1'b1}}));
      send_span(14'd1, 17'd5);
      send_word(32'hFFFFFFFF);

      // darkest fade clamps at zero; base rewritten while a span is open
      settle();
      write_reg(CSR_FADE_AMOUNT, fade_value(-255));
      write_reg(CSR_DEST_BASE, '0);
      csr_valid <= 1'b0;
      send_word(span_header(14'd2, {SKIP_WIDTH{1'b1}}));
      send_word(32'hFFFFFFFF);
      send_word(32'h80FF0001);
      send_word(span_header(14'd3, '0));
      send_word(pixel_sample());
      settle();
      write_reg(CSR_DEST_BASE, 30'h15555555);
      csr_valid <= 1'b0;
      send_word(pixel_sample());
      send_word(pixel_sample());
      send_word(32'h80000000);

      // write to an unmapped index is dropped; neutral fade
      settle();
      write_reg(CSR_UNMAPPED, {CSR_DATA_WIDTH{1'b1}});
      write_reg(CSR_FADE_AMOUNT, fade_value(0));
      csr_valid <= 1'b0;
      send_span(14'd1, '0);
      end_image();

      // random phases of images with fresh settings
      phase = 0;
      while (words_sent < RANDOM_WORDS) begin
         settle();
         write_reg(CSR_DEST_BASE, draw_base());
         write_reg(CSR_FADE_AMOUNT, fade_value(draw_fade()));
         csr_valid <= 1'b0;
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         phase++;
         if (phase == 3) begin
            send_span(LEN_WIDTH'($urandom_range(200, 400)), draw_skip());
            end_image();
         end
         begin
            int stop_at;
            stop_at = words_sent + PHASE_WORDS;
            while (words_sent < stop_at) begin
               case ($urandom_range(0, 9))
                  0: end_image();
                  1: send_span(LEN_WIDTH'($urandom_range(0, 2)), draw_skip());
                  default: begin
                     repeat ($urandom_range(1, 5)) send_span(draw_len(), draw_skip());
                     end_image();
                  end
               endcase
            end
         end
      end

      // drain and verdict
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (END_PAUSE) @(posedge clock);
      $display("sent %0d stream words over %0d register writes", words_sent, settings_written);
      $display("checked %0d pixel writes and %0d image ends", writes_seen, ends_seen);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
